// ===== rtl/core/monte_carlo_call_pricer_top_defines.svh =====
// Assertion macros shared by the Monte Carlo call pricer RTL.
`ifndef MONTE_CARLO_CALL_PRICER_TOP_DEFINES_SVH
`define MONTE_CARLO_CALL_PRICER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MCCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MCCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MCCP_ASSERT(lbl, prop, msg)
`define MCCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/mccp_pkg.sv =====
// Package with constants, register codes and control types of the call pricer.
`default_nettype none
package mccp_pkg;

  localparam int SAMPLE_FRAC_BITS_DEF = 12;
  localparam int COUNT_WIDTH_DEF      = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // ln 2 in Q.20 and its scaled reciprocal for the range reduction.
  localparam logic [19:0] LN2_Q20 = 20'd726817;
  localparam int          RCP_SHIFT = 40;
  localparam logic [20:0] LN2_RCP = 21'((64'd1 << RCP_SHIFT) / 64'd726817);
  // Offset that makes the clamped exponent non-negative: twelve times ln 2.
  localparam logic [24:0] EXP_OFFSET = 25'(12 * 726817);
  localparam logic signed [40:0] EXP_LIMIT = 41'sd8388608;

  localparam int          SERIES_TERMS = 12;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [4:0]  SHIFT_BASE = 5'd26;
  // Series terms are divided by their index through a reciprocal scaled by 2^34.
  localparam int          TERM_RCP_SHIFT = 34;

  localparam int DIV_W       = 64;
  localparam int DIV_STEPS_W = 7;
  localparam logic [DIV_STEPS_W-1:0] MEAN_STEPS = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPOT     = 3'd0,
    REG_STRIKE   = 3'd1,
    REG_DRIFT    = 3'd2,
    REG_DIFFUSE  = 3'd3,
    REG_DISCOUNT = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic load_in;
    logic prod;
    logic expn;
    logic rcp;
    logic red;
    logic corr;
    logic tmul;
    logic trcp;
    logic term_take;
    logic price;
    logic pay;
    logic div_mean;
    logic mean_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic div_busy;
    logic term_last;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/mccp_ifs.sv =====
// Handshake interfaces for the sample, result and configuration channels.
`default_nettype none
interface mccp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_sample;
  logic               last_sample;
  modport source (output valid, normal_sample, last_sample, input ready);
  modport sink   (input valid, normal_sample, last_sample, output ready);
endinterface

interface mccp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] option_price;
  logic        saturated;
  modport source (output valid, option_price, saturated, input ready);
  modport sink   (input valid, option_price, saturated, output ready);
endinterface

interface mccp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mccp_pkg::CFG_IDX_W-1:0]      index;
  logic [mccp_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mccp_div.sv =====
// Bit-serial restoring divider for the mean payoff.
`default_nettype none
module mccp_div #(
  parameter int VW = mccp_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [mccp_pkg::DIV_W-1:0]          dividend_i,
  input  wire logic [VW-1:0]                       divisor_i,
  input  wire logic [mccp_pkg::DIV_STEPS_W-1:0]    steps_i,
  output logic                                     busy_o,
  output logic [mccp_pkg::DIV_W-1:0]               quotient_o
);
  localparam int DW = mccp_pkg::DIV_W;

  logic [DW-1:0]                    dvd_q, dvd_d;
  logic [VW-1:0]                    rem_q, rem_d, dsr_q;
  logic [mccp_pkg::DIV_STEPS_W-1:0] cnt_q, cnt_d;
  logic [VW:0]                      rem_sh;
  logic                             ge;

  // Dividend is left aligned so that after the given steps the register holds the quotient.
  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      cnt_d = steps_i;
    end else if (cnt_q != '0) begin
      dvd_d = {dvd_q[DW-2:0], ge};
      rem_d = ge ? VW'(rem_sh - {1'b0, dsr_q}) : rem_sh[VW-1:0];
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = dvd_q;
endmodule
`default_nettype wire

// ===== rtl/core/mccp_dp.sv =====
// Datapath: exponent, series exp, payoff accumulation, mean and output register.
`default_nettype none
module mccp_dp #(
  parameter int SAMPLE_FRAC_BITS = mccp_pkg::SAMPLE_FRAC_BITS_DEF,
  parameter int COUNT_WIDTH      = mccp_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mccp_pkg::cmd_t     cmd_i,
  output mccp_pkg::sts_t          sts_o,
  input  wire logic               in_valid_i,
  input  wire logic signed [15:0] normal_sample_i,
  input  wire logic               last_sample_i,
  input  wire logic [15:0]        spot_i,
  input  wire logic [15:0]        strike_i,
  input  wire logic signed [23:0] drift_i,
  input  wire logic [22:0]        diffusion_i,
  input  wire logic [31:0]        discount_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [31:0]             option_price_o,
  output logic                    saturated_o
);
  logic signed [15:0] z_q;
  logic               last_q;
  logic signed [39:0] prod_q;
  logic [24:0]        u_q;
  logic [4:0]         n_q;
  logic [20:0]        r_q;
  logic [30:0]        term_q;
  logic [29:0]        tp_q;
  logic [63:0]        tq_q;
  logic [31:0]        e_q;
  logic [3:0]         i_q;
  logic [47:0]        pm_q;
  logic [31:0]        mean_q;
  logic [63:0]        sum_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic               sat_q;
  logic               out_valid_q;
  logic [31:0]        out_price_q;
  logic               out_sat_q;

  logic signed [39:0] prod_sh;
  logic signed [40:0] x_raw;
  logic signed [25:0] x_cl;
  logic [45:0]        rcp_prod;
  logic [24:0]        nl_prod;
  logic [59:0]        tmul;
  logic [29:0]        r30;
  logic [33:0]        term_rcp;
  logic [30:0]        term_quo;
  logic [44:0]        price;
  logic [44:0]        payoff;
  logic [64:0]        sum_new;
  logic [63:0]        disc_prod;
  logic               div_busy;
  logic [63:0]        div_quo;

  assign prod_sh = prod_q >>> SAMPLE_FRAC_BITS;
  assign x_raw   = {prod_sh[39], prod_sh} + 41'(drift_i);
  always_comb begin
    if (x_raw > mccp_pkg::EXP_LIMIT) begin
      x_cl = 26'(mccp_pkg::EXP_LIMIT);
    end else if (x_raw < -mccp_pkg::EXP_LIMIT) begin
      x_cl = 26'(-mccp_pkg::EXP_LIMIT);
    end else begin
      x_cl = 26'(x_raw);
    end
  end

  // Reciprocals ceil(2^34 / i) of the term indexes. The term product stays below
  // 2^30, so the scaled quotient equals the floor of the division.
  always_comb begin
    case (i_q)
      4'd2:    term_rcp = 34'd8589934592;
      4'd3:    term_rcp = 34'd5726623062;
      4'd4:    term_rcp = 34'd4294967296;
      4'd5:    term_rcp = 34'd3435973837;
      4'd6:    term_rcp = 34'd2863311531;
      4'd7:    term_rcp = 34'd2454267027;
      4'd8:    term_rcp = 34'd2147483648;
      4'd9:    term_rcp = 34'd1908874354;
      4'd10:   term_rcp = 34'd1717986919;
      4'd11:   term_rcp = 34'd1561806290;
      4'd12:   term_rcp = 34'd1431655766;
      default: term_rcp = '0;
    endcase
  end

  assign rcp_prod = 46'(u_q) * 46'(mccp_pkg::LN2_RCP);
  assign nl_prod  = 25'(n_q) * 25'(mccp_pkg::LN2_Q20);
  assign r30      = {r_q[19:0], 10'b0};
  assign tmul     = 60'(term_q) * 60'(r30);
  // The first term is divided by one and passes straight through.
  assign term_quo = (i_q == 4'd1) ? {1'b0, tp_q} : 31'(tq_q >> mccp_pkg::TERM_RCP_SHIFT);
  assign price    = 45'(pm_q >> (mccp_pkg::SHIFT_BASE - n_q));
  assign payoff   = (price > {13'b0, strike_i, 16'b0}) ? price - {13'b0, strike_i, 16'b0} : '0;
  assign disc_prod = 64'(mean_q) * 64'(discount_i);

  mccp_div #(.VW(COUNT_WIDTH)) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.div_mean),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .steps_i    (mccp_pkg::MEAN_STEPS),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      z_q    <= normal_sample_i;
      last_q <= last_sample_i;
    end
    if (cmd_i.prod) prod_q <= $signed({1'b0, diffusion_i}) * 40'(z_q);
    if (cmd_i.expn) u_q <= 25'(x_cl + 26'(mccp_pkg::EXP_OFFSET));
    if (cmd_i.rcp) n_q <= rcp_prod[44:40];
    if (cmd_i.red) r_q <= 21'(u_q - nl_prod);
    if (cmd_i.corr) begin
      if (r_q >= 21'(mccp_pkg::LN2_Q20)) begin
        r_q <= r_q - 21'(mccp_pkg::LN2_Q20);
        n_q <= n_q + 1'b1;
      end
      term_q <= mccp_pkg::ONE_Q30;
      e_q    <= 32'(mccp_pkg::ONE_Q30);
      i_q    <= 4'd1;
    end
    if (cmd_i.tmul) tp_q <= tmul[59:30];
    if (cmd_i.trcp) tq_q <= 64'(tp_q) * 64'(term_rcp);
    if (cmd_i.term_take) begin
      term_q <= term_quo;
      e_q    <= e_q + 32'(term_quo);
      i_q    <= i_q + 1'b1;
    end
    if (cmd_i.price) pm_q <= 48'(spot_i) * 48'(e_q);
    if (cmd_i.mean_take) begin
      mean_q <= (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
    end
    if (cmd_i.out_load) begin
      out_price_q <= disc_prod[63:32];
      out_sat_q   <= sat_q;
    end
  end

  assign sum_new = {1'b0, sum_q} + 65'(payoff[31:0] | {32{payoff[44:32] != '0}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.pay) begin
        sum_q   <= sum_new[64] ? '1 : sum_new[63:0];
        count_q <= (count_q == '1) ? count_q : count_q + 1'b1;
        if (payoff[44:32] != '0 || sum_new[64] || count_q == '1) sat_q <= 1'b1;
      end
      if (cmd_i.mean_take && div_quo[63:32] != '0) sat_q <= 1'b1;
      if (cmd_i.out_load) begin
        sum_q   <= '0;
        count_q <= '0;
        sat_q   <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.in_valid  = in_valid_i;
  assign sts_o.last      = last_q;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.term_last = i_q == 4'(mccp_pkg::SERIES_TERMS);
  assign sts_o.out_full  = out_valid_q;

  assign out_valid_o    = out_valid_q;
  assign option_price_o = out_price_q;
  assign saturated_o    = out_sat_q;
endmodule
`default_nettype wire

// ===== rtl/core/mccp_ctrl.sv =====
// Controller state machine sequencing one sample through the datapath.
`default_nettype none
`include "monte_carlo_call_pricer_top_defines.svh"
module mccp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mccp_pkg::sts_t sts_i,
  output mccp_pkg::cmd_t      cmd_o,
  output logic                in_ready_o
);
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_PROD   = 14'b00000000000010,
    S_EXPN   = 14'b00000000000100,
    S_RCP    = 14'b00000000001000,
    S_RED    = 14'b00000000010000,
    S_CORR   = 14'b00000000100000,
    S_TMUL   = 14'b00000001000000,
    S_TRCP   = 14'b00000010000000,
    S_TTAKE  = 14'b00000100000000,
    S_PRICE  = 14'b00001000000000,
    S_PAY    = 14'b00010000000000,
    S_MSTART = 14'b00100000000000,
    S_MWAIT  = 14'b01000000000000,
    S_DMUL   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (sts_i.in_valid) begin
          cmd_o.load_in = 1'b1;
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d = S_EXPN;
      end
      S_EXPN: begin
        cmd_o.expn = 1'b1;
        state_d = S_RCP;
      end
      S_RCP: begin
        cmd_o.rcp = 1'b1;
        state_d = S_RED;
      end
      S_RED: begin
        cmd_o.red = 1'b1;
        state_d = S_CORR;
      end
      S_CORR: begin
        cmd_o.corr = 1'b1;
        state_d = S_TMUL;
      end
      S_TMUL: begin
        cmd_o.tmul = 1'b1;
        state_d = S_TRCP;
      end
      S_TRCP: begin
        cmd_o.trcp = 1'b1;
        state_d = S_TTAKE;
      end
      S_TTAKE: begin
        cmd_o.term_take = 1'b1;
        state_d = sts_i.term_last ? S_PRICE : S_TMUL;
      end
      S_PRICE: begin
        cmd_o.price = 1'b1;
        state_d = S_PAY;
      end
      S_PAY: begin
        cmd_o.pay = 1'b1;
        state_d = sts_i.last ? S_MSTART : S_IDLE;
      end
      S_MSTART: begin
        cmd_o.div_mean = 1'b1;
        state_d = S_MWAIT;
      end
      S_MWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.mean_take = 1'b1;
          state_d = S_DMUL;
        end
      end
      S_DMUL: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  `MCCP_ASSERT(a_accept_starts, (sts_i.in_valid && in_ready_o) |=> (state_q == S_PROD), "accepted sample did not start")
  `MCCP_ASSERT(a_div_free, cmd_o.div_mean |-> !sts_i.div_busy, "divider started while busy")
  `MCCP_ASSERT_ALWAYS(a_out_free, cmd_o.out_load |-> !sts_i.out_full, "result overwrote a pending result")
endmodule
`default_nettype wire

// ===== rtl/core/monte_carlo_call_pricer_top.sv =====
// Top level of the Monte Carlo European call pricer.
// Usage:
//   in_i carries one standard normal sample (Q3.12) per transfer with a last_sample mark.
//   Every sample adds its call payoff to a running sum; the sample marked last
//   causes one transfer on out_o with the discounted mean payoff (Q16.16) and a
//   flag that tells whether any payoff, the sum, the count or the mean saturated.
//   cfg_i writes the five registers (spot, strike, drift, diffusion, discount) by
//   index; writes beyond the last index are ignored. Write only while idle.
// Sample sequence:
//   A sample is processed fully before the input is ready again: an accept state,
//   the exponent and range reduction states (product, exponent, reciprocal, reduction,
//   correction), then for each of the twelve series terms of exp a term product, a
//   reciprocal multiply by the term index and an accumulate, then price and payoff
//   accumulation. A last sample adds the 64-step mean division and the discount multiply.
// Reset:
//   Registers return to spot 100, strike 110, zero drift and diffusion and a
//   discount of all ones; sum, count and flag clear; no result is pending.
// Stall:
//   The result waits in an output register while the block keeps accepting samples;
//   a further result holds the block, and its input, until the pending one is taken.
`default_nettype none
module monte_carlo_call_pricer_top #(
  parameter int SAMPLE_FRAC_BITS = mccp_pkg::SAMPLE_FRAC_BITS_DEF,
  parameter int COUNT_WIDTH      = mccp_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mccp_in_if.sink    in_i,
  mccp_out_if.source out_o,
  mccp_cfg_if.sink   cfg_i
);
  // Configuration registers.
  logic [15:0]        spot_q, strike_q;
  logic signed [23:0] drift_q;
  logic [22:0]        diffusion_q;
  logic [31:0]        discount_q;

  mccp_pkg::cmd_t cmd;
  mccp_pkg::sts_t sts;
  logic           in_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spot_q      <= 16'd100;
      strike_q    <= 16'd110;
      drift_q     <= '0;
      diffusion_q <= '0;
      discount_q  <= '1;
    end else if (cfg_i.valid) begin
      unique case (mccp_pkg::cfg_reg_e'(cfg_i.index))
        mccp_pkg::REG_SPOT:     spot_q      <= cfg_i.data[15:0];
        mccp_pkg::REG_STRIKE:   strike_q    <= cfg_i.data[15:0];
        mccp_pkg::REG_DRIFT:    drift_q     <= $signed(cfg_i.data[23:0]);
        mccp_pkg::REG_DIFFUSE:  diffusion_q <= cfg_i.data[22:0];
        mccp_pkg::REG_DISCOUNT: discount_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The controller sequences one sample at a time through the datapath.
  mccp_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  assign in_i.ready = in_ready;

  mccp_dp #(
    .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS),
    .COUNT_WIDTH      (COUNT_WIDTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_valid_i      (in_i.valid),
    .normal_sample_i (in_i.normal_sample),
    .last_sample_i   (in_i.last_sample),
    .spot_i          (spot_q),
    .strike_i        (strike_q),
    .drift_i         (drift_q),
    .diffusion_i     (diffusion_q),
    .discount_i      (discount_q),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .option_price_o  (out_o.option_price),
    .saturated_o     (out_o.saturated)
  );
endmodule
`default_nettype wire
